FILE: hdl/i2cm_pkg.sv
package i2cm_pkg;

   // request codes
   localparam logic [2:0] REQ_NONE       = 3'd0;
   localparam logic [2:0] REQ_START      = 3'd1;
   localparam logic [2:0] REQ_STOP       = 3'd2;
   localparam logic [2:0] REQ_WRITE      = 3'd3;
   localparam logic [2:0] REQ_CHECK_ACK  = 3'd4;
   localparam logic [2:0] REQ_READ       = 3'd5;
   localparam logic [2:0] REQ_MASTER_ACK = 3'd6;

   // sequencer phase codes
   localparam logic [4:0] PH_IDLE          = 5'd0;
   localparam logic [4:0] PH_START_IDLE_HI = 5'd1;
   localparam logic [4:0] PH_START_SDA_LO  = 5'd2;
   localparam logic [4:0] PH_START_SCL_LO  = 5'd3;
   localparam logic [4:0] PH_STOP_LOW      = 5'd4;
   localparam logic [4:0] PH_STOP_SCL_HI   = 5'd5;
   localparam logic [4:0] PH_STOP_SDA_HI   = 5'd6;
   localparam logic [4:0] PH_WR_SETUP      = 5'd7;
   localparam logic [4:0] PH_WR_HIGH       = 5'd8;
   localparam logic [4:0] PH_WR_TAIL       = 5'd9;
   localparam logic [4:0] PH_ACK_SETUP     = 5'd10;
   localparam logic [4:0] PH_ACK_HIGH      = 5'd11;
   localparam logic [4:0] PH_ACK_TAIL      = 5'd12;
   localparam logic [4:0] PH_RD_SETUP      = 5'd13;
   localparam logic [4:0] PH_RD_HIGH       = 5'd14;
   localparam logic [4:0] PH_RD_TAIL       = 5'd15;
   localparam logic [4:0] PH_MA_SETUP      = 5'd16;
   localparam logic [4:0] PH_MA_HIGH       = 5'd17;
   localparam logic [4:0] PH_MA_TAIL       = 5'd18;
   localparam logic [4:0] PH_LAST          = PH_MA_TAIL;

   localparam logic [7:0] TPM_RESET = 8'd1;

   typedef struct packed {
      logic [2:0] req_type;
      logic [7:0] write_byte;
      logic       master_nack;
      logic       sda_sample;
   } i2cm_req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       sda_drive;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       slave_nack;
   } i2cm_rsp_type;

   typedef struct packed {
      logic [4:0] phase;
      logic [3:0] bit_count;
      logic [2:0] us_count;
      logic [7:0] presc_count;
      logic [7:0] shift_byte;
      logic       scl;
      logic       sda;
      logic       drv;
      logic [7:0] last_read;
      logic       last_nack;
   } i2cm_state_type;

endpackage

FILE: hdl/i2cm_step.sv
module i2cm_step
   import i2cm_pkg::*;
(
   input  i2cm_state_type cur_state,
   input  i2cm_req_type   req,
   input  logic [7:0]     tpm,
   output i2cm_state_type nxt_state,
   output i2cm_rsp_type   rsp
);

   // microseconds spent in each phase
   function automatic logic [2:0] phase_delay(input logic [4:0] p);
      logic [2:0] d;
      d = 3'd2;
      unique case (p)
         PH_IDLE:                             d = 3'd0;
         PH_START_IDLE_HI, PH_STOP_SDA_HI:    d = 3'd5;
         PH_START_SCL_LO, PH_WR_TAIL, PH_ACK_TAIL,
         PH_RD_TAIL, PH_MA_TAIL:              d = 3'd1;
         default:                             d = 3'd2;
      endcase
      return d;
   endfunction

   // line levels on entry to a phase
   function automatic i2cm_state_type enter_phase(input i2cm_state_type s,
                                                  input logic [4:0] p);
      i2cm_state_type r;
      r = s;
      r.phase       = p;
      r.us_count    = 3'd0;
      r.presc_count = 8'd0;
      unique case (p)
         PH_START_IDLE_HI: begin
            r.scl = 1'b1; r.sda = 1'b1; r.drv = 1'b1;
         end
         PH_START_SDA_LO: r.sda = 1'b0;
         PH_STOP_LOW: begin
            r.scl = 1'b0; r.sda = 1'b0; r.drv = 1'b1;
         end
         PH_STOP_SCL_HI: r.scl = 1'b1;
         PH_STOP_SDA_HI: r.sda = 1'b1;
         PH_WR_SETUP: begin
            r.scl = 1'b0; r.drv = 1'b1; r.sda = s.shift_byte[7];
         end
         PH_ACK_SETUP, PH_RD_SETUP: begin
            r.scl = 1'b0; r.drv = 1'b0; r.sda = 1'b1;
         end
         PH_MA_SETUP: begin
            r.scl = 1'b0; r.drv = 1'b1;
         end
         PH_WR_HIGH, PH_ACK_HIGH, PH_RD_HIGH, PH_MA_HIGH: r.scl = 1'b1;
         default: r.scl = 1'b0;
      endcase
      return r;
   endfunction

   logic [7:0] tick_div;
   logic       us_end;
   logic       done;

   assign tick_div = (tpm == 8'd0) ? 8'd1 : tpm;
   assign us_end   = ({1'b0, cur_state.presc_count} + 9'd1) >= {1'b0, tick_div};

   always_comb begin
      nxt_state = cur_state;
      done      = 1'b0;
      if (cur_state.phase == PH_IDLE || cur_state.phase > PH_LAST) begin
         nxt_state.phase     = PH_IDLE;
         nxt_state.bit_count = 4'd0;
         unique case (req.req_type)
            REQ_START: nxt_state = enter_phase(nxt_state, PH_START_IDLE_HI);
            REQ_STOP:  nxt_state = enter_phase(nxt_state, PH_STOP_LOW);
            REQ_WRITE: begin
               nxt_state.shift_byte = req.write_byte;
               nxt_state = enter_phase(nxt_state, PH_WR_SETUP);
            end
            REQ_CHECK_ACK: nxt_state = enter_phase(nxt_state, PH_ACK_SETUP);
            REQ_READ: begin
               nxt_state.shift_byte = 8'd0;
               nxt_state = enter_phase(nxt_state, PH_RD_SETUP);
            end
            REQ_MASTER_ACK: begin
               nxt_state.sda = req.master_nack;
               nxt_state = enter_phase(nxt_state, PH_MA_SETUP);
            end
            default: ;
         endcase
      end else if (us_end) begin
         nxt_state.presc_count = 8'd0;
         nxt_state.us_count    = cur_state.us_count + 3'd1;
         if (nxt_state.us_count >= phase_delay(cur_state.phase)) begin
            unique case (cur_state.phase)
               PH_ACK_HIGH: begin
                  nxt_state.last_nack = req.sda_sample;
                  nxt_state = enter_phase(nxt_state, PH_ACK_TAIL);
               end
               PH_RD_HIGH: begin
                  nxt_state.shift_byte = {cur_state.shift_byte[6:0], req.sda_sample};
                  nxt_state = enter_phase(nxt_state, PH_RD_TAIL);
               end
               PH_WR_TAIL: begin
                  nxt_state.shift_byte = {cur_state.shift_byte[6:0], 1'b0};
                  nxt_state.bit_count  = cur_state.bit_count + 4'd1;
                  if (nxt_state.bit_count >= 4'd8) begin
                     nxt_state.phase = PH_IDLE;
                     done = 1'b1;
                  end else begin
                     nxt_state = enter_phase(nxt_state, PH_WR_SETUP);
                  end
               end
               PH_RD_TAIL: begin
                  nxt_state.bit_count = cur_state.bit_count + 4'd1;
                  if (nxt_state.bit_count >= 4'd8) begin
                     nxt_state.last_read = cur_state.shift_byte;
                     nxt_state.phase     = PH_IDLE;
                     done = 1'b1;
                  end else begin
                     nxt_state = enter_phase(nxt_state, PH_RD_SETUP);
                  end
               end
               PH_START_SCL_LO, PH_STOP_SDA_HI, PH_ACK_TAIL, PH_MA_TAIL: begin
                  nxt_state.phase = PH_IDLE;
                  done = 1'b1;
               end
               default: nxt_state = enter_phase(nxt_state, cur_state.phase + 5'd1);
            endcase
         end
      end else begin
         nxt_state.presc_count = cur_state.presc_count + 8'd1;
      end
   end

   always_comb begin
      rsp.scl_level  = nxt_state.scl;
      rsp.sda_level  = nxt_state.drv ? nxt_state.sda : 1'b1;
      rsp.sda_drive  = nxt_state.drv;
      rsp.busy_res   = (nxt_state.phase != PH_IDLE);
      rsp.done_res   = done;
      rsp.read_byte  = nxt_state.last_read;
      rsp.slave_nack = nxt_state.last_nack;
   end

endmodule

FILE: hdl/i2cm_skid.sv
module i2cm_skid
   import i2cm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  i2cm_rsp_type push_data,
   output logic         full,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output i2cm_rsp_type rsp_data
);

   logic         main_valid_ff, main_valid_in;
   logic         spare_valid_ff, spare_valid_in;
   i2cm_rsp_type main_data_ff, main_data_in;
   i2cm_rsp_type spare_data_ff, spare_data_in;
   logic         pop;

   assign pop = main_valid_ff && !rsp_stall;

   always_comb begin
      main_valid_in  = main_valid_ff;
      spare_valid_in = spare_valid_ff;
      main_data_in   = main_data_ff;
      spare_data_in  = spare_data_ff;
      if (spare_valid_ff) begin
         if (pop) begin
            main_data_in   = spare_data_ff;
            spare_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!main_valid_ff || pop) begin
            main_data_in  = push_data;
            main_valid_in = 1'b1;
         end else begin
            spare_data_in  = push_data;
            spare_valid_in = 1'b1;
         end
      end else if (pop) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
      main_data_ff  <= main_data_in;
      spare_data_ff <= spare_data_in;
   end

   assign full      = spare_valid_ff;
   assign rsp_valid = main_valid_ff;
   assign rsp_data  = main_data_ff;

endmodule

FILE: hdl/i2c_master_bit_engine.sv
// i2c master bit engine: one request transaction is one bus timing tick
// the response transaction for a tick is registered in the response buffer before it is offered
// throughput: one transaction per cycle while req_stall is low, set by the registered state update
// req_stall is registered and rises only when the two-entry response buffer is full
// reset: synchronous active high, sequencer idle, scl/sda high and driven, divider 1
module i2c_master_bit_engine
   import i2cm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // request channel
   input  logic         req_valid,
   output logic         req_stall,
   input  i2cm_req_type req_data,
   // response channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output i2cm_rsp_type rsp_data,
   // divider register
   input  logic         csr_write_en,
   input  logic [7:0]   csr_write_data
);

   // sequencer state, advanced once per accepted transaction
   i2cm_state_type state_ff, state_in;
   i2cm_state_type step_state;
   i2cm_rsp_type   step_rsp;
   // ticks per microsecond
   logic [7:0]     tpm_ff, tpm_in;
   logic           req_accept;
   logic           buf_full;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = buf_full;

   // next state and response for the current tick
   i2cm_step u_step (
      .cur_state (state_ff),
      .req       (req_data),
      .tpm       (tpm_ff),
      .nxt_state (step_state),
      .rsp       (step_rsp)
   );

   assign state_in = req_accept ? step_state : state_ff;
   assign tpm_in   = csr_write_en ? csr_write_data : tpm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= PH_IDLE;
         state_ff.bit_count   <= 4'd0;
         state_ff.us_count    <= 3'd0;
         state_ff.presc_count <= 8'd0;
         state_ff.shift_byte  <= 8'd0;
         state_ff.scl         <= 1'b1;
         state_ff.sda         <= 1'b1;
         state_ff.drv         <= 1'b1;
         state_ff.last_read   <= 8'd0;
         state_ff.last_nack   <= 1'b0;
         tpm_ff               <= TPM_RESET;
      end else begin
         state_ff <= state_in;
         tpm_ff   <= tpm_in;
      end
   end

   // response register with skid entry so a stalled consumer does not block a tick until the skid entry is full
   i2cm_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (step_rsp),
      .full      (buf_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTH
   // a completing command is already idle on its done tick
   a_done_not_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> !(step_rsp.done_res && step_rsp.busy_res))
      else $error("done and busy together");

   // a full skid entry means the output register holds a transaction
   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("stall with empty response register");

   // sequencer only moves on an accepted tick
   a_state_hold: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff))
      else $error("state changed without a transaction");

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.phase <= PH_LAST)
      else $error("phase out of range");
`endif

endmodule
